// File: src/xo_pkg.sv
// ----------------------------------------------------------------------------
// xo_pkg: shared types, constants and microcode for the xoshiro256++ generator
// holds the opcode set, the control word layout and the micro-program rom
// ----------------------------------------------------------------------------
package xo_pkg;

  // operation codes carried in tuser
  typedef enum logic [1:0] {
    OP_DRAW = 2'd0,
    OP_SEED = 2'd1,
    OP_JUMP = 2'd2
  } opcode_t;

  typedef logic [3:0][63:0] words_t;

  // splitmix64 and seeding constants
  localparam logic [63:0] GOLDEN       = 64'h9e3779b97f4a7c15;
  localparam logic [63:0] MIX1         = 64'hbf58476d1ce4e5b9;
  localparam logic [63:0] MIX2         = 64'h94d049bb133111eb;
  localparam logic [63:0] DEFAULT_SEED = {32'd1802, 32'd9373};

  // jump polynomial, word 0 in the lowest bits
  localparam int unsigned JUMP_BITS = 256;
  localparam logic [JUMP_BITS-1:0] JUMP_POLY = {
    64'h39abdc4529b1661c, 64'ha9582618e03fc9aa,
    64'hd5a61266f0c9392c, 64'h180ec6d33cfd0aba
  };

  // xoshiro256++ rotations and shift
  localparam int unsigned ROT_OUT   = 23;
  localparam int unsigned SHIFT_T   = 17;
  localparam int unsigned ROT_STATE = 45;

  // loop counter
  typedef logic [7:0] lc_t;
  localparam int unsigned SEED_WORDS = 4;
  localparam lc_t SEED_LAST = lc_t'(SEED_WORDS - 1);
  localparam lc_t JUMP_LAST = lc_t'(JUMP_BITS - 1);

  // micro-program addresses
  typedef logic [4:0] upc_t;
  localparam upc_t UA_IDLE      = 5'd0;
  localparam upc_t UA_RESET     = 5'd1;
  localparam upc_t UA_SEED      = 5'd2;
  localparam upc_t UA_JUMP      = 5'd15;
  localparam upc_t UA_JUMP_BIT  = 5'd16;
  localparam upc_t UA_JUMP_END  = 5'd17;

  typedef enum logic [1:0] {
    SM_HOLD, SM_LOAD_DEFAULT, SM_ADD_GOLDEN
  } sm_op_t;

  typedef enum logic [2:0] {
    Z_HOLD, Z_LOAD_SM, Z_XS30, Z_XS27, Z_LOAD_PROD
  } z_op_t;

  typedef enum logic [1:0] {
    MUL_HOLD, MUL_FIRST, MUL_ACC
  } mul_op_t;

  typedef enum logic [1:0] {
    W_HOLD, W_SHIFT_IN, W_ADVANCE, W_LOAD_ACC
  } w_op_t;

  typedef enum logic [1:0] {
    ACC_HOLD, ACC_CLEAR, ACC_JUMP_BIT
  } acc_op_t;

  typedef enum logic {
    CNT_HOLD, CNT_CLEAR
  } cnt_op_t;

  typedef enum logic {
    LC_HOLD, LC_INC
  } lc_op_t;

  typedef enum logic [1:0] {
    SEQ_NEXT, SEQ_BRANCH, SEQ_END
  } seq_op_t;

  typedef enum logic [1:0] {
    COND_ALWAYS, COND_LC_NOT_SEED_LAST, COND_LC_NOT_JUMP_LAST
  } cond_t;

  typedef struct packed {
    sm_op_t  sm_op;
    z_op_t   z_op;
    mul_op_t mul_op;
    logic    mul_ahi;
    logic    mul_bhi;
    logic    mul_c2;
    w_op_t   w_op;
    acc_op_t acc_op;
    cnt_op_t cnt_op;
    lc_op_t  lc_op;
    seq_op_t seq_op;
    cond_t   cond;
    upc_t    target;
  } ctrl_t;

  localparam ctrl_t CTRL_NOP = '{
    sm_op: SM_HOLD, z_op: Z_HOLD, mul_op: MUL_HOLD, mul_ahi: 1'b0,
    mul_bhi: 1'b0, mul_c2: 1'b0, w_op: W_HOLD, acc_op: ACC_HOLD,
    cnt_op: CNT_HOLD, lc_op: LC_HOLD, seq_op: SEQ_NEXT,
    cond: COND_ALWAYS, target: UA_IDLE
  };

  // one splitmix step per pass over the seed rows, four passes
  function automatic ctrl_t xo_ucode(upc_t addr);
    ctrl_t c;
    c = CTRL_NOP;
    unique case (addr)
      5'd1: begin
        c.sm_op = SM_LOAD_DEFAULT;
      end
      5'd2: begin
        c.sm_op = SM_ADD_GOLDEN;
        c.z_op  = Z_LOAD_SM;
      end
      5'd3: c.z_op = Z_XS30;
      5'd4: c.mul_op = MUL_FIRST;
      5'd5: begin
        c.mul_op  = MUL_ACC;
        c.mul_bhi = 1'b1;
      end
      5'd6: begin
        c.mul_op  = MUL_ACC;
        c.mul_ahi = 1'b1;
      end
      5'd7: c.z_op = Z_LOAD_PROD;
      5'd8: c.z_op = Z_XS27;
      5'd9: begin
        c.mul_op = MUL_FIRST;
        c.mul_c2 = 1'b1;
      end
      5'd10: begin
        c.mul_op  = MUL_ACC;
        c.mul_bhi = 1'b1;
        c.mul_c2  = 1'b1;
      end
      5'd11: begin
        c.mul_op  = MUL_ACC;
        c.mul_ahi = 1'b1;
        c.mul_c2  = 1'b1;
      end
      5'd12: c.z_op = Z_LOAD_PROD;
      5'd13: begin
        c.w_op   = W_SHIFT_IN;
        c.lc_op  = LC_INC;
        c.seq_op = SEQ_BRANCH;
        c.cond   = COND_LC_NOT_SEED_LAST;
        c.target = UA_SEED;
      end
      5'd14: begin
        c.cnt_op = CNT_CLEAR;
        c.seq_op = SEQ_END;
      end
      5'd15: c.acc_op = ACC_CLEAR;
      5'd16: begin
        c.acc_op = ACC_JUMP_BIT;
        c.w_op   = W_ADVANCE;
        c.lc_op  = LC_INC;
        c.seq_op = SEQ_BRANCH;
        c.cond   = COND_LC_NOT_JUMP_LAST;
        c.target = UA_JUMP_BIT;
      end
      5'd17: begin
        c.w_op   = W_LOAD_ACC;
        c.seq_op = SEQ_END;
      end
      default: c = CTRL_NOP;
    endcase
    return c;
  endfunction

  function automatic logic [63:0] xo_rotl(logic [63:0] v, int unsigned amount);
    return (v << amount) | (v >> (64 - amount));
  endfunction

  // raw output for the current state
  function automatic logic [63:0] xo_output(words_t w);
    return xo_rotl(w[0] + w[3], ROT_OUT) + w[0];
  endfunction

  // one state transition
  function automatic words_t xo_advance(words_t w);
    words_t      n;
    logic [63:0] t;
    t    = w[1] << SHIFT_T;
    n    = w;
    n[2] = n[2] ^ n[0];
    n[3] = n[3] ^ n[1];
    n[1] = n[1] ^ n[2];
    n[0] = n[0] ^ n[3];
    n[2] = n[2] ^ t;
    n[3] = xo_rotl(n[3], ROT_STATE);
    return n;
  endfunction

endpackage

// File: src/xo_useq.sv
// ----------------------------------------------------------------------------
// xo_useq: micro-program sequencer
// step counter, loop counter and control rom for the seed and jump routines
// ----------------------------------------------------------------------------
module xo_useq (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             go,
  input  xo_pkg::upc_t     go_addr,
  output xo_pkg::ctrl_t    ctrl,
  output xo_pkg::lc_t      loop_idx,
  output logic             idle
);

  xo_pkg::upc_t upc_r, upc_nxt;
  xo_pkg::lc_t  lc_r, lc_nxt;
  logic         cond_ok;

  assign ctrl     = xo_pkg::xo_ucode(upc_r);
  assign loop_idx = lc_r;
  assign idle     = (upc_r == xo_pkg::UA_IDLE);

  always_comb begin
    unique case (ctrl.cond)
      xo_pkg::COND_LC_NOT_SEED_LAST: cond_ok = (lc_r != xo_pkg::SEED_LAST);
      xo_pkg::COND_LC_NOT_JUMP_LAST: cond_ok = (lc_r != xo_pkg::JUMP_LAST);
      default:                       cond_ok = 1'b1;
    endcase
  end

  always_comb begin
    upc_nxt = upc_r;
    if (idle) begin
      upc_nxt = go ? go_addr : xo_pkg::UA_IDLE;
    end else begin
      unique case (ctrl.seq_op)
        xo_pkg::SEQ_BRANCH: upc_nxt = cond_ok ? ctrl.target : upc_r + 5'd1;
        xo_pkg::SEQ_END:    upc_nxt = xo_pkg::UA_IDLE;
        default:            upc_nxt = upc_r + 5'd1;
      endcase
    end
  end

  always_comb begin
    if (go) begin
      lc_nxt = '0;
    end else if (ctrl.lc_op == xo_pkg::LC_INC) begin
      lc_nxt = lc_r + 8'd1;
    end else begin
      lc_nxt = lc_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upc_r <= xo_pkg::UA_RESET;
      lc_r  <= '0;
    end else begin
      upc_r <= upc_nxt;
      lc_r  <= lc_nxt;
    end
  end

endmodule

// File: src/xoshiro256pp_generator.sv
// ----------------------------------------------------------------------------
// xoshiro256pp_generator: xoshiro256++ random number generator
// draw, seed (splitmix64) and 2^128 jump, controlled by a small micro-program
// ----------------------------------------------------------------------------
// draw: result beat registered in the cycle after the input beat, one draw per cycle while the result beat is taken
// seed: busy after the input beat for four passes over 12 splitmix microcode steps and a final step
// jump: busy, one jump polynomial bit per cycle over 256 bits
// reset: rst_n low, then the built-in seeding routine (1802, 9373) runs
// before in_tready rises; the draw count starts at zero
module xoshiro256pp_generator (
  input  logic         clk,
  input  logic         rst_n,
  // input beats
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [63:0]  in_tdata,   // [31:0] seed_high, [63:32] seed_low
  input  logic [1:0]   in_tuser,   // [1:0] opcode
  // result beats
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [183:0] out_tdata   // [63:0] random_word, [116:64] unit_fraction,
                                   // [180:117] draws_so_far, [183:181] zero
);

  // sequencer interface
  xo_pkg::ctrl_t ctrl;
  xo_pkg::lc_t   loop_idx;
  logic          seq_idle;
  logic          go;
  xo_pkg::upc_t  go_addr;

  // datapath registers
  xo_pkg::words_t w_r, w_nxt;       // generator state
  xo_pkg::words_t acc_r, acc_nxt;   // jump accumulator
  logic [63:0]    sm_r, sm_nxt;     // splitmix seed
  logic [63:0]    z_r, z_nxt;       // splitmix mixing word
  logic [63:0]    prod_r, prod_nxt; // partial product sum
  logic [63:0]    cnt_r, cnt_nxt;   // draws since seeding

  // output register
  logic           out_valid_r, out_valid_nxt;
  logic [183:0]   out_data_r, out_data_nxt;

  // handshake
  logic           in_acc;
  logic           draw_acc;
  logic           seed_acc;
  logic [63:0]    draw_word;

  // shared 32x32 multiplier
  logic [63:0]    mul_const;
  logic [31:0]    mul_a;
  logic [31:0]    mul_b;
  logic [63:0]    mul_p;

  xo_useq u_useq (
    .clk      (clk),
    .rst_n    (rst_n),
    .go       (go),
    .go_addr  (go_addr),
    .ctrl     (ctrl),
    .loop_idx (loop_idx),
    .idle     (seq_idle)
  );

  // new beats only when the routines are idle and the output slot is free
  assign in_tready = seq_idle && (!out_valid_r || out_tready);
  assign in_acc    = in_tvalid && in_tready;
  assign draw_acc  = in_acc && (in_tuser == xo_pkg::OP_DRAW);
  assign seed_acc  = in_acc && (in_tuser == xo_pkg::OP_SEED);
  // unused opcode is taken and dropped
  assign go        = seed_acc || (in_acc && (in_tuser == xo_pkg::OP_JUMP));
  assign go_addr   = seed_acc ? xo_pkg::UA_SEED : xo_pkg::UA_JUMP;

  assign draw_word = xo_pkg::xo_output(w_r);

  // low 64 bits of z * constant as three 32x32 partial products
  assign mul_const = ctrl.mul_c2 ? xo_pkg::MIX2 : xo_pkg::MIX1;
  assign mul_a     = ctrl.mul_ahi ? z_r[63:32] : z_r[31:0];
  assign mul_b     = ctrl.mul_bhi ? mul_const[63:32] : mul_const[31:0];
  assign mul_p     = mul_a * mul_b;

  // splitmix seed
  always_comb begin
    sm_nxt = sm_r;
    if (seed_acc) begin
      sm_nxt = {in_tdata[31:0], in_tdata[63:32]};
    end else begin
      unique case (ctrl.sm_op)
        xo_pkg::SM_LOAD_DEFAULT: sm_nxt = xo_pkg::DEFAULT_SEED;
        xo_pkg::SM_ADD_GOLDEN:   sm_nxt = sm_r + xo_pkg::GOLDEN;
        default:                 sm_nxt = sm_r;
      endcase
    end
  end

  // mixing word
  always_comb begin
    unique case (ctrl.z_op)
      xo_pkg::Z_LOAD_SM:   z_nxt = sm_r + xo_pkg::GOLDEN;
      xo_pkg::Z_XS30:      z_nxt = z_r ^ (z_r >> 30);
      xo_pkg::Z_XS27:      z_nxt = z_r ^ (z_r >> 27);
      xo_pkg::Z_LOAD_PROD: z_nxt = prod_r;
      default:             z_nxt = z_r;
    endcase
  end

  // cross terms only reach the upper half
  always_comb begin
    unique case (ctrl.mul_op)
      xo_pkg::MUL_FIRST: prod_nxt = mul_p;
      xo_pkg::MUL_ACC:   prod_nxt = prod_r + {mul_p[31:0], 32'd0};
      default:           prod_nxt = prod_r;
    endcase
  end

  // generator state
  always_comb begin
    w_nxt = w_r;
    if (draw_acc) begin
      w_nxt = xo_pkg::xo_advance(w_r);
    end else begin
      unique case (ctrl.w_op)
        // finished splitmix word enters at the top, first one ends in word 0
        xo_pkg::W_SHIFT_IN: w_nxt = {z_r ^ (z_r >> 31), w_r[3], w_r[2], w_r[1]};
        xo_pkg::W_ADVANCE:  w_nxt = xo_pkg::xo_advance(w_r);
        xo_pkg::W_LOAD_ACC: w_nxt = acc_r;
        default:            w_nxt = w_r;
      endcase
    end
  end

  // jump accumulator, one polynomial bit per step
  always_comb begin
    unique case (ctrl.acc_op)
      xo_pkg::ACC_CLEAR:    acc_nxt = '0;
      xo_pkg::ACC_JUMP_BIT: acc_nxt = xo_pkg::JUMP_POLY[loop_idx] ? (acc_r ^ w_r) : acc_r;
      default:              acc_nxt = acc_r;
    endcase
  end

  // draw count, wraps at 2^64
  always_comb begin
    if (draw_acc) begin
      cnt_nxt = cnt_r + 64'd1;
    end else if (ctrl.cnt_op == xo_pkg::CNT_CLEAR) begin
      cnt_nxt = '0;
    end else begin
      cnt_nxt = cnt_r;
    end
  end

  // result beat register
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (draw_acc) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = {3'd0, cnt_r + 64'd1, draw_word[63:11], draw_word};
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
      acc_r       <= '0;
    end else begin
      out_valid_r <= out_valid_nxt;
      cnt_r       <= cnt_nxt;
      acc_r       <= acc_nxt;
    end
  end

  // state words are filled by the reset seeding routine
  always_ff @(posedge clk) begin
    w_r        <= w_nxt;
    sm_r       <= sm_nxt;
    z_r        <= z_nxt;
    prod_r     <= prod_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // a draw beat always gives a result beat next cycle
  a_draw_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    draw_acc |=> out_valid_r)
    else $error("draw beat without result beat");

  // count advances by exactly one per draw
  a_draw_counts: assert property (@(posedge clk) disable iff (!rst_n)
    draw_acc |=> (cnt_r == $past(cnt_r) + 64'd1))
    else $error("draw count did not advance");

  // seed and jump routines hold off new beats
  a_routine_busy: assert property (@(posedge clk) disable iff (!rst_n)
    go |=> !in_tready)
    else $error("input taken while routine starts");

  // no result appears while a routine runs
  a_no_result_in_routine: assert property (@(posedge clk) disable iff (!rst_n)
    (!seq_idle && !out_valid_r) |=> !out_valid_r)
    else $error("result beat during seed or jump");

endmodule
